// ===== src/scsd_pkg.sv =====
`timescale 1ns / 1ps

package scsd_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = 32;

  // fixed port widths
  localparam int FN_ADDR_W = 32;
  localparam int SHOWN_W   = 6;
  localparam int DELTA_W   = 32;
  localparam int DEPTH_W   = 16;

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int NIB_N = (ADDR_W + 3) / 4;

  localparam logic [1:0] FUNC_ENTER = 2'd0;
  localparam logic [1:0] FUNC_EXIT  = 2'd1;
  localparam logic [1:0] FUNC_DUMP  = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic                 is_header;
    logic [SHOWN_W-1:0]   depth_shown;
    logic [SHOWN_W-1:0]   match_count;
    logic [DELTA_W-1:0]   delta_value;
    logic                 last;
  } out_word_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    addr_t wdata;
    logic  re;
    idx_t  raddr;
  } store_req_t;

endpackage

// ===== src/scsd_in_if.sv =====
`timescale 1ns / 1ps

interface scsd_in_if;
  import scsd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [FN_ADDR_W-1:0] fn_addr;

  modport source (output valid, output func, output fn_addr, input ready);
  modport sink   (input valid, input func, input fn_addr, output ready);
endinterface

// ===== src/scsd_out_if.sv =====
`timescale 1ns / 1ps

interface scsd_out_if;
  import scsd_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_header;
  logic [SHOWN_W-1:0] depth_shown;
  logic [SHOWN_W-1:0] match_count;
  logic [DELTA_W-1:0] delta_value;
  logic               last;

  modport source (output valid, output is_header, output depth_shown,
                  output match_count, output delta_value, output last,
                  input ready);
  modport sink   (input valid, input is_header, input depth_shown,
                  input match_count, input delta_value, input last,
                  output ready);
endinterface

// ===== src/scsd_store.sv =====
`timescale 1ns / 1ps

module scsd_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scsd_pkg::store_req_t  req_i,
  output scsd_pkg::addr_t       rdata_o
);
  import scsd_pkg::*;

  addr_t                  mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] vld_q;
  addr_t                  rdata_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== src/scsd_nibble_delta.sv =====
`timescale 1ns / 1ps

module scsd_nibble_delta (
  input  scsd_pkg::addr_t a_i,
  input  scsd_pkg::addr_t b_i,
  output scsd_pkg::addr_t delta_o,
  output logic            eq_o
);
  import scsd_pkg::*;

  logic [NIB_N-1:0] diff;
  logic [NIB_N-1:0] above;
  logic             run;

  // keep every nibble at or below the highest one that differs
  always_comb begin
    diff  = '0;
    above = '0;
    run   = 1'b0;
    for (int k = 0; k < ADDR_W; k++) begin
      if (a_i[k] != b_i[k]) begin
        diff[k/4] = 1'b1;
      end
    end
    for (int n = NIB_N - 1; n >= 0; n--) begin
      run      = run | diff[n];
      above[n] = run;
    end
    for (int k = 0; k < ADDR_W; k++) begin
      delta_o[k] = a_i[k] & above[k/4];
    end
  end

  assign eq_o = ~|diff;

endmodule

// ===== src/shadow_call_stack_delta_dump.sv =====
`timescale 1ns / 1ps
// Enter, exit and unused codes: handled in idle, ready again the next cycle.
// Dump with m matching entries out of n shown: entries are compared in turn
// up to a mismatch or the end, then header and delta words are loaded one by
// one, serialised by the single compare/delta unit and one store read port.
// Output stalls hold the sequencer. Reset (rst_ni low, async) clears depth
// and the per-entry valid bits of both stores at once, no clearing pass.

module shadow_call_stack_delta_dump (
  input logic        clk_i,
  input logic        rst_ni,
  scsd_in_if.sink    in_i,
  scsd_out_if.source out_o
);
  import scsd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MRD  = 6'b000010,
    S_MCMP = 6'b000100,
    S_HDR  = 6'b001000,
    S_DRD  = 6'b010000,
    S_DOUT = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  cnt_t               shown_q, shown_d;
  cnt_t               idx_q, idx_d;
  addr_t              prior_q, prior_d;
  out_word_t          word_q, word_d;
  logic               ovld_q, ovld_d;

  store_req_t stk_req, prv_req;
  addr_t      stk_data, prv_data;
  addr_t      unit_b, unit_delta;
  logic       unit_eq;
  logic       in_fire, slot_free;
  addr_t      in_addr;

  scsd_store u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (stk_req),
    .rdata_o (stk_data)
  );

  scsd_store u_prev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (prv_req),
    .rdata_o (prv_data)
  );

  // shared unit: compare against previous dump, or delta against prior entry
  assign unit_b = (state_q == S_MCMP) ? prv_data : prior_q;

  scsd_nibble_delta u_delta (
    .a_i     (stk_data),
    .b_i     (unit_b),
    .delta_o (unit_delta),
    .eq_o    (unit_eq)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !ovld_q || out_o.ready;
  assign in_addr    = ADDR_W'(in_i.fn_addr);

  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    shown_d = shown_q;
    idx_d   = idx_q;
    prior_d = prior_q;
    word_d  = word_q;
    ovld_d  = ovld_q && !out_o.ready;

    stk_req       = '0;
    stk_req.waddr = depth_q[IDX_W-1:0];
    stk_req.wdata = in_addr;
    stk_req.raddr = idx_q[IDX_W-1:0];
    prv_req       = '0;
    prv_req.waddr = idx_q[IDX_W-1:0];
    prv_req.wdata = stk_data;
    prv_req.raddr = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.func == FUNC_ENTER) begin
            stk_req.we = (depth_q < DEPTH_W'(STACK_DEPTH));
            depth_d    = depth_q + 1'b1;
          end else if (in_i.func == FUNC_EXIT) begin
            if (depth_q != '0) begin
              depth_d = depth_q - 1'b1;
            end
          end else if (in_i.func == FUNC_DUMP) begin
            shown_d = (depth_q > DEPTH_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH)
                                                        : CNT_W'(depth_q);
            idx_d   = '0;
            prior_d = '0;
            state_d = S_MRD;
          end
        end
      end
      S_MRD: begin
        if (idx_q == shown_q) begin
          state_d = S_HDR;
        end else begin
          stk_req.re = 1'b1;
          prv_req.re = 1'b1;
          state_d    = S_MCMP;
        end
      end
      S_MCMP: begin
        if (unit_eq) begin
          prior_d = stk_data;
          idx_d   = idx_q + 1'b1;
          state_d = S_MRD;
        end else begin
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        if (slot_free) begin
          ovld_d             = 1'b1;
          word_d.is_header   = 1'b1;
          word_d.depth_shown = SHOWN_W'(shown_q);
          word_d.match_count = SHOWN_W'(idx_q);
          word_d.delta_value = '0;
          word_d.last        = (idx_q == shown_q);
          state_d            = (idx_q == shown_q) ? S_IDLE : S_DRD;
        end
      end
      S_DRD: begin
        stk_req.re = 1'b1;
        state_d    = S_DOUT;
      end
      S_DOUT: begin
        if (slot_free) begin
          ovld_d             = 1'b1;
          word_d.is_header   = 1'b0;
          word_d.depth_shown = '0;
          word_d.match_count = '0;
          word_d.delta_value = DELTA_W'(unit_delta);
          word_d.last        = (idx_q + 1'b1 == shown_q);
          prv_req.we         = 1'b1;
          prior_d            = stk_data;
          idx_d              = idx_q + 1'b1;
          state_d            = (idx_q + 1'b1 == shown_q) ? S_IDLE : S_DRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shown_q <= shown_d;
    idx_q   <= idx_d;
    prior_q <= prior_d;
    word_q  <= word_d;
  end

  assign out_o.valid       = ovld_q;
  assign out_o.is_header   = word_q.is_header;
  assign out_o.depth_shown = word_q.depth_shown;
  assign out_o.match_count = word_q.match_count;
  assign out_o.delta_value = word_q.delta_value;
  assign out_o.last        = word_q.last;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import scsd_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         RAND_WORDS   = 56;
  localparam int         DRAIN_CYCLES = 200;
  localparam int         CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [1:0]           func;
    logic [FN_ADDR_W-1:0] addr;
    logic                 typed;
    logic [SHOWN_W-1:0]   exp_shown;
    logic [SHOWN_W-1:0]   exp_match;
    logic                 exp_last;
  } call_row_t;

  // hand-checked dump headers where the answer is obvious
  localparam call_row_t DIRECTED [22] = '{
    '{FUNC_DUMP,   32'h0000_0000, 1'b1, 6'd0, 6'd0, 1'b1},
    '{FUNC_EXIT,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_UNUSED, 32'hFFFF_FFFF, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_ENTER,  32'hFFFF_FFFF, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_ENTER,  32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_ENTER,  32'hFFFF_FFF0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_ENTER,  32'hFFFF_FFF0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_DUMP,   32'h0000_0000, 1'b1, 6'd4, 6'd0, 1'b0},
    '{FUNC_DUMP,   32'hFFFF_FFFF, 1'b1, 6'd4, 6'd4, 1'b1},
    '{FUNC_EXIT,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_ENTER,  32'h1234_5678, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_DUMP,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_EXIT,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_EXIT,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_EXIT,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_EXIT,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_DUMP,   32'h0000_0000, 1'b1, 6'd0, 6'd0, 1'b1},
    '{FUNC_ENTER,  32'h0F0F_0F0F, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_ENTER,  32'hF0F0_F0F0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_DUMP,   32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_UNUSED, 32'h0000_0000, 1'b0, 6'd0, 6'd0, 1'b0},
    '{FUNC_DUMP,   32'h0000_0000, 1'b1, 6'd2, 6'd2, 1'b1}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  scsd_in_if  in_if ();
  scsd_out_if out_if ();

  shadow_call_stack_delta_dump uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted call stack
  addr_t              stk_mem   [STACK_DEPTH];
  addr_t              last_dump [STACK_DEPTH];
  logic [DEPTH_W-1:0] call_depth;
  out_word_t          dump_q [$];

  addr_t addr_pool [4];
  addr_t last_addr;
  int    send_idle_pct;
  int    stall_pct;
  int    fails;
  int    cycle_cnt;

  function automatic addr_t strip_nibbles(addr_t a, addr_t prior);
    addr_t keep;
    keep = '1;
    while (keep != '0 && (a & keep) != (prior & keep))
      keep = keep << 4;
    return a & ~keep;
  endfunction

  // returns the number of words queued for this call event
  function automatic int predict_calls(logic [1:0] f, addr_t a);
    int        shown;
    int        m;
    int        n;
    addr_t     prior;
    out_word_t w;
    n = 0;
    case (f)
      FUNC_ENTER: begin
        if (call_depth < STACK_DEPTH)
          stk_mem[call_depth] = a;
        call_depth = call_depth + 1'b1;
      end
      FUNC_EXIT: begin
        if (call_depth != '0)
          call_depth = call_depth - 1'b1;
      end
      FUNC_DUMP: begin
        shown = (call_depth > STACK_DEPTH) ? STACK_DEPTH : int'(call_depth);
        prior = '0;
        m = 0;
        while (m < shown && stk_mem[m] == last_dump[m]) begin
          prior = stk_mem[m];
          m++;
        end
        w = '0;
        w.is_header   = 1'b1;
        w.depth_shown = SHOWN_W'(shown);
        w.match_count = SHOWN_W'(m);
        w.last        = (m == shown);
        dump_q.push_back(w);
        n = 1;
        for (; m < shown; m++) begin
          w = '0;
          w.delta_value = DELTA_W'(strip_nibbles(stk_mem[m], prior));
          w.last        = (m + 1 == shown);
          dump_q.push_back(w);
          last_dump[m] = stk_mem[m];
          prior = stk_mem[m];
          n++;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic addr_t next_addr();
    addr_t mask;
    int    k;
    case ($urandom_range(4))
      0: return addr_t'($urandom);
      1: return addr_pool[$urandom_range(3)];
      2: begin
        // keep the upper nibbles of the last address, vary the low ones
        k = $urandom_range(7, 1);
        mask = (addr_t'(1) << (4 * k)) - 1'b1;
        return (last_addr & ~mask) | (addr_t'($urandom) & mask);
      end
      default: return last_addr;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // called and returns at a falling edge; valid stays high between words unless idle cycles are inserted
  task automatic send_word(input call_row_t r);
    int        n;
    int        h;
    out_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= r.func;
    in_if.fn_addr <= r.addr;
    do @(posedge clk_i); while (!in_if.ready);
    n = predict_calls(r.func, addr_t'(r.addr));
    if (r.typed) begin
      h = dump_q.size() - n;
      w = dump_q[h];
      w.depth_shown = r.exp_shown;
      w.match_count = r.exp_match;
      w.last        = r.exp_last;
      dump_q[h] = w;
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_if.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : out_mon
    out_word_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (dump_q.size() == 0) begin
        $error("output word with nothing expected");
        fails++;
      end else begin
        w = dump_q.pop_front();
        check_field("is_header", 32'(w.is_header), 32'(out_if.is_header));
        check_field("depth_shown", 32'(w.depth_shown), 32'(out_if.depth_shown));
        check_field("match_count", 32'(w.match_count), 32'(out_if.match_count));
        check_field("delta_value", 32'(w.delta_value), 32'(out_if.delta_value));
        check_field("last", 32'(w.last), 32'(out_if.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stim
    call_row_t r;
    int        rand_words;
    int        target;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.func    = FUNC_ENTER;
    in_if.fn_addr = '0;
    out_if.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    fails         = 0;
    cycle_cnt     = 0;
    call_depth    = '0;
    last_addr     = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stk_mem[i]   = '0;
      last_dump[i] = '0;
    end
    for (int i = 0; i < 4; i++)
      addr_pool[i] = addr_t'($urandom);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i])
      send_word(DIRECTED[i]);

    // fill the stack and go past its end; extra enters only move the depth
    r = '0;
    r.func = FUNC_ENTER;
    while (call_depth < DEPTH_W'(STACK_DEPTH + 2)) begin
      r.addr = $urandom;
      send_word(r);
    end
    r = '0;
    r.func = FUNC_DUMP;
    send_word(r);
    r.func = FUNC_ENTER;
    r.addr = $urandom;
    send_word(r);
    r = '{FUNC_DUMP, 32'h0, 1'b1, 6'd32, 6'd32, 1'b1};
    send_word(r);

    // random walks to a target depth, each closed by a dump
    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      case (rand_words * 5 / RAND_WORDS)
        1:       begin send_idle_pct = 51; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 51; end
        3:       begin send_idle_pct = 13; stall_pct = 13; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      target = ($urandom_range(9) == 0) ? $urandom_range(36, 30) : $urandom_range(12);
      while (call_depth != target) begin
        r = '0;
        if ($urandom_range(9) == 0)
          r.func = 2'($urandom_range(3));
        else
          r.func = (call_depth < target) ? FUNC_ENTER : FUNC_EXIT;
        r.addr = next_addr();
        send_word(r);
        if (r.func == FUNC_ENTER)
          last_addr = r.addr;
        if (r.func != FUNC_UNUSED)
          rand_words++;
      end
      r = '0;
      r.func = FUNC_DUMP;
      r.addr = $urandom;
      send_word(r);
      rand_words++;
      if ($urandom_range(4) == 0) begin
        send_word(r);
        rand_words++;
      end
    end
    in_if.valid <= 1'b0;

    while (dump_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
